@@ sv/box_frustum_cull_top_macros.svh @@
// assertion macros for the box frustum cull block
`ifndef BOX_FRUSTUM_CULL_TOP_MACROS_SVH
`define BOX_FRUSTUM_CULL_TOP_MACROS_SVH

// same-cycle implication, off during reset
`define BFC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define BFC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, always checked
`define BFC_ASSERT_NXT_ALL(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/bfc_pkg.sv @@
// types and constants for the box frustum cull block
package bfc_pkg;

    localparam int NUM_PLANES = 6;
    localparam int NUM_AXES   = 3;
    localparam int NORM_W     = 14;
    localparam int OFF_W      = 22;
    localparam int EPS_W      = 16;
    localparam int PLANE_W    = 64;
    localparam int FRAC_SHIFT = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int VIS_W      = 2;

    localparam logic [CFG_IDX_W-1:0] IDX_EPSILON = 3'd6;
    localparam logic [EPS_W-1:0]     EPS_RESET   = 16'd5;

    localparam logic [VIS_W-1:0] VIS_OUTSIDE = 2'd0;
    localparam logic [VIS_W-1:0] VIS_INSIDE  = 2'd1;
    localparam logic [VIS_W-1:0] VIS_PARTIAL = 2'd2;

    typedef struct packed {
        logic [OFF_W-1:0]  offset;
        logic [NORM_W-1:0] nz;
        logic [NORM_W-1:0] ny;
        logic [NORM_W-1:0] nx;
    } t_plane;

    typedef struct packed {
        logic [EPS_W-1:0]              eps;
        t_plane [NUM_PLANES-1:0]       planes;
    } t_cfg;

    typedef struct packed {
        logic far_behind;
        logic near_behind;
    } t_plane_res;

endpackage

@@ sv/bfc_box_if.sv @@
// box channel: center and half extents
interface bfc_box_if #(
    parameter int COORD_BITS = 24
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] center_x;
    logic signed [COORD_BITS-1:0] center_y;
    logic signed [COORD_BITS-1:0] center_z;
    logic        [COORD_BITS-2:0] half_x;
    logic        [COORD_BITS-2:0] half_y;
    logic        [COORD_BITS-2:0] half_z;

    modport source (
        output valid, center_x, center_y, center_z, half_x, half_y, half_z,
        input  ready
    );
    modport sink (
        input  valid, center_x, center_y, center_z, half_x, half_y, half_z,
        output ready
    );
endinterface

@@ sv/bfc_vis_if.sv @@
// result channel: visibility code
interface bfc_vis_if;
    logic       valid;
    logic       ready;
    logic [1:0] visibility;

    modport source (
        output valid, visibility,
        input  ready
    );
    modport sink (
        input  valid, visibility,
        output ready
    );
endinterface

@@ sv/bfc_cfg_regs.sv @@
// plane and epsilon configuration registers
module bfc_cfg_regs
    import bfc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [PLANE_W-1:0]   i_cfg_wdata,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.planes <= '0;
            r_cfg.eps    <= EPS_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx < CFG_IDX_W'(NUM_PLANES)) begin
                r_cfg.planes[i_cfg_idx] <= i_cfg_wdata;
            end else if (i_cfg_idx == IDX_EPSILON) begin
                r_cfg.eps <= i_cfg_wdata[EPS_W-1:0];
            end
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ sv/bfc_plane_mul.sv @@
// per-plane product stage: center times normal, half times normal magnitude
module bfc_plane_mul
    import bfc_pkg::*;
#(
    parameter int COORD_BITS = 24
) (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [COORD_BITS-1:0]        i_c  [NUM_AXES],
    input  logic        [COORD_BITS-2:0]        i_h  [NUM_AXES],
    input  t_plane                              i_plane,
    output logic signed [COORD_BITS+NORM_W-1:0] o_cn [NUM_AXES],
    output logic        [COORD_BITS+NORM_W-2:0] o_hn [NUM_AXES]
);

    logic signed [NORM_W-1:0]            w_n   [NUM_AXES];
    logic        [NORM_W-1:0]            w_abs [NUM_AXES];
    logic signed [COORD_BITS+NORM_W-1:0] n_cn  [NUM_AXES];
    logic        [COORD_BITS+NORM_W-2:0] n_hn  [NUM_AXES];
    logic signed [COORD_BITS+NORM_W-1:0] r_cn  [NUM_AXES];
    logic        [COORD_BITS+NORM_W-2:0] r_hn  [NUM_AXES];

    assign w_n[0] = $signed(i_plane.nx);
    assign w_n[1] = $signed(i_plane.ny);
    assign w_n[2] = $signed(i_plane.nz);

    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            w_abs[a] = w_n[a][NORM_W-1] ? (~w_n[a] + NORM_W'(1)) : w_n[a];
            n_cn[a]  = i_c[a] * w_n[a];
            n_hn[a]  = i_h[a] * w_abs[a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cn <= n_cn;
            r_hn <= n_hn;
        end
    end

    assign o_cn = r_cn;
    assign o_hn = r_hn;

endmodule

@@ sv/bfc_plane_test.sv @@
// per-plane distance sums and compare against the tolerance
module bfc_plane_test
    import bfc_pkg::*;
#(
    parameter int COORD_BITS = 24
) (
    input  logic signed [COORD_BITS+NORM_W-1:0] i_cn [NUM_AXES],
    input  logic        [COORD_BITS+NORM_W-2:0] i_hn [NUM_AXES],
    input  logic        [OFF_W-1:0]             i_off,
    input  logic        [EPS_W-1:0]             i_eps,
    output t_plane_res                          o_res
);

    localparam int DW = (COORD_BITS + 18 > 36) ? COORD_BITS + 18 : 36;

    logic signed [DW-1:0] w_cn_sum;
    logic signed [DW-1:0] w_hn_sum;
    logic signed [DW-1:0] w_off;
    logic signed [DW-1:0] w_thr;
    logic signed [DW-1:0] w_far;
    logic signed [DW-1:0] w_near;

    assign w_cn_sum = DW'(i_cn[0]) + DW'(i_cn[1]) + DW'(i_cn[2]);
    assign w_hn_sum = $signed(DW'(i_hn[0])) + $signed(DW'(i_hn[1]))
                    + $signed(DW'(i_hn[2]));
    assign w_off    = DW'($signed({i_off, {FRAC_SHIFT{1'b0}}}));
    assign w_thr    = -$signed(DW'({i_eps, {FRAC_SHIFT{1'b0}}}));
    assign w_far    = w_cn_sum + w_hn_sum + w_off;
    assign w_near   = w_cn_sum - w_hn_sum + w_off;

    assign o_res.far_behind  = (w_far < w_thr);
    assign o_res.near_behind = (w_near < w_thr);

endmodule

@@ sv/box_frustum_cull_top.sv @@
// box frustum cull top level: three-register pipeline with config registers
//
//  channel   dir  payload                            handshake
//  i_box     in   center_x/y/z, half_x/y/z           valid/ready
//  o_vis     out  visibility                         valid/ready
//  i_cfg_*   in   idx, wdata (planes 0..5, epsilon)  we only
//
// one box per cycle while o_vis does not stall
// stages: input register, product register (36 multipliers), result register
// each stage advances when empty or when the next one advances, so a stall
// on o_vis backs up stage by stage and input is still taken while bubbles exist
// synchronous reset clears valid bits, planes to zero and epsilon to 5
module box_frustum_cull_top
    import bfc_pkg::*;
#(
    parameter int COORD_BITS = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    bfc_box_if.sink              i_box,
    bfc_vis_if.source            o_vis,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [PLANE_W-1:0]   i_cfg_wdata
);

    t_cfg w_cfg;

    logic r_v1, r_v2, r_v3;
    logic w_rdy1, w_rdy2, w_rdy3;

    logic signed [COORD_BITS-1:0] r_c [NUM_AXES];
    logic        [COORD_BITS-2:0] r_h [NUM_AXES];

    logic signed [COORD_BITS+NORM_W-1:0] w_cn [NUM_PLANES][NUM_AXES];
    logic        [COORD_BITS+NORM_W-2:0] w_hn [NUM_PLANES][NUM_AXES];
    t_plane_res                          w_res [NUM_PLANES];

    logic [VIS_W-1:0] n_vis;
    logic [VIS_W-1:0] r_vis;

    bfc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    assign w_rdy3 = !r_v3 || o_vis.ready;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;
    assign i_box.ready = w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_box.valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_box.valid) begin
            r_c[0] <= i_box.center_x;
            r_c[1] <= i_box.center_y;
            r_c[2] <= i_box.center_z;
            r_h[0] <= i_box.half_x;
            r_h[1] <= i_box.half_y;
            r_h[2] <= i_box.half_z;
        end
    end

    for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
        bfc_plane_mul #(.COORD_BITS(COORD_BITS)) u_mul (
            .i_clk   (i_clk),
            .i_en    (w_rdy2 && r_v1),
            .i_c     (r_c),
            .i_h     (r_h),
            .i_plane (w_cfg.planes[p]),
            .o_cn    (w_cn[p]),
            .o_hn    (w_hn[p])
        );

        bfc_plane_test #(.COORD_BITS(COORD_BITS)) u_test (
            .i_cn  (w_cn[p]),
            .i_hn  (w_hn[p]),
            .i_off (w_cfg.planes[p].offset),
            .i_eps (w_cfg.eps),
            .o_res (w_res[p])
        );
    end

    always_comb begin
        logic any_far;
        logic any_near;
        any_far  = 1'b0;
        any_near = 1'b0;
        for (int p = 0; p < NUM_PLANES; p++) begin
            any_far  = any_far  | w_res[p].far_behind;
            any_near = any_near | w_res[p].near_behind;
        end
        priority if (any_far) begin
            n_vis = VIS_OUTSIDE;
        end else if (any_near) begin
            n_vis = VIS_PARTIAL;
        end else begin
            n_vis = VIS_INSIDE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy3 && r_v2) begin
            r_vis <= n_vis;
        end
    end

    assign o_vis.valid      = r_v3;
    assign o_vis.visibility = r_vis;

endmodule

@@ sv/bfc_checker.sv @@
// port-level checker for the box frustum cull top level, with bind
`include "box_frustum_cull_top_macros.svh"

module bfc_checker
    import bfc_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [VIS_W-1:0] i_vis
);

    `BFC_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_vis), "stalled result changed")
    `BFC_ASSERT_IMP(a_ready_when_empty, i_clk, i_rst_n, !i_out_valid, i_in_ready, "input stalled with empty output")
    `BFC_ASSERT_NXT_ALL(a_reset_clears, i_clk, !i_rst_n, !i_out_valid, "result valid right after reset")
    `BFC_ASSERT_IMP(a_vis_code, i_clk, i_rst_n, i_out_valid, i_vis == VIS_OUTSIDE || i_vis == VIS_INSIDE || i_vis == VIS_PARTIAL, "bad visibility code")

endmodule

bind box_frustum_cull_top bfc_checker u_bfc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_box.ready),
    .i_out_valid (o_vis.valid),
    .i_out_ready (o_vis.ready),
    .i_vis       (o_vis.visibility)
);

@@ test/box_frustum_cull_top_tb.sv @@
// testbench for box_frustum_cull_top: directed and random boxes against a plane-test predictor
`timescale 1ns / 100ps

module box_frustum_cull_top_tb
    import bfc_pkg::*;
;

    localparam int COORD_BITS  = 24;
    localparam int ITEMS_PHASE = 250;
    localparam int DRAIN_CYCLES = 8;
    localparam int TIMEOUT_NS  = 2_000_000;

    localparam int MAX_C = 8388607;
    localparam int MIN_C = -8388608;
    localparam int MAX_H = 8388607;
    localparam int MAX_NORM = 8191;
    localparam int MIN_NORM = -8192;
    localparam int UNIT_NORM = 4096;
    localparam int DIAG_NORM = 2896;
    localparam int MAX_OFF = 2097151;
    localparam int MIN_OFF = -2097152;
    localparam int FRUSTUM_W = 256000;

    localparam logic [CFG_IDX_W-1:0] IDX_LAST_PLANE = CFG_IDX_W'(NUM_PLANES - 1);
    localparam logic [CFG_IDX_W-1:0] IDX_UNUSED     = 3'd7;

    typedef struct packed {
        logic [COORD_BITS-1:0] cx;
        logic [COORD_BITS-1:0] cy;
        logic [COORD_BITS-1:0] cz;
        logic [COORD_BITS-2:0] hx;
        logic [COORD_BITS-2:0] hy;
        logic [COORD_BITS-2:0] hz;
    } t_box;

    class cull_scoreboard;
        t_plane           planes [NUM_PLANES];
        logic [EPS_W-1:0] eps;
        logic [VIS_W-1:0] pending_vis [$];
        int               errors;
        int               boxes;
        int               seen [3];

        function new();
            foreach (planes[i]) planes[i] = '0;
            eps = EPS_RESET;
            errors = 0;
            boxes = 0;
            foreach (seen[i]) seen[i] = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [PLANE_W-1:0] data);
            if (idx < NUM_PLANES) begin
                planes[idx] = data;
            end else if (idx == IDX_EPSILON) begin
                eps = data[EPS_W-1:0];
            end
        endfunction

        function logic [VIS_W-1:0] cull_box(t_box b);
            longint           c [NUM_AXES];
            longint           h [NUM_AXES];
            longint           n [NUM_AXES];
            longint           far_pt [NUM_AXES];
            longint           near_pt [NUM_AXES];
            longint           off, lim, d_far, d_near;
            logic [VIS_W-1:0] vis;
            c[0] = $signed(b.cx);
            c[1] = $signed(b.cy);
            c[2] = $signed(b.cz);
            h[0] = b.hx;
            h[1] = b.hy;
            h[2] = b.hz;
            lim = -(longint'(eps) <<< FRAC_SHIFT);
            vis = VIS_INSIDE;
            // stop at the first plane that rejects the box
            for (int p = 0; p < NUM_PLANES && vis != VIS_OUTSIDE; p++) begin
                n[0] = $signed(planes[p].nx);
                n[1] = $signed(planes[p].ny);
                n[2] = $signed(planes[p].nz);
                off = $signed(planes[p].offset);
                for (int a = 0; a < NUM_AXES; a++) begin
                    far_pt[a]  = (n[a] >= 0) ? c[a] + h[a] : c[a] - h[a];
                    near_pt[a] = (n[a] >= 0) ? c[a] - h[a] : c[a] + h[a];
                end
                d_far = far_pt[0] * n[0] + far_pt[1] * n[1] + far_pt[2] * n[2]
                        + (off <<< FRAC_SHIFT);
                d_near = near_pt[0] * n[0] + near_pt[1] * n[1] + near_pt[2] * n[2]
                         + (off <<< FRAC_SHIFT);
                if (d_far < lim) begin
                    vis = VIS_OUTSIDE;
                end else if (d_near < lim) begin
                    vis = VIS_PARTIAL;
                end
            end
            return vis;
        endfunction

        function void note_box(t_box b);
            pending_vis.push_back(cull_box(b));
            boxes++;
        endfunction

        function void check_vis(logic [VIS_W-1:0] got);
            logic [VIS_W-1:0] want;
            if (pending_vis.size() == 0) begin
                errors++;
                $display("%0t: visibility %0d with no box pending", $time, got);
                return;
            end
            want = pending_vis.pop_front();
            seen[want]++;
            if (got !== want) begin
                errors++;
                $display("%0t: visibility mismatch, expected %0d, got %0d", $time, want, got);
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [PLANE_W-1:0]   i_cfg_wdata;

    int                 gap_pct = 0;
    int                 stall_pct = 0;
    int                 world_w = FRUSTUM_W;
    int                 n_sets = 0;
    logic [PLANE_W-1:0] plane_set [NUM_PLANES];

    cull_scoreboard cull_board = new();

    bfc_box_if #(.COORD_BITS(COORD_BITS)) box_if ();
    bfc_vis_if vis_if ();

    box_frustum_cull_top #(
        .COORD_BITS(COORD_BITS)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_box       (box_if),
        .o_vis       (vis_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("** box_frustum_cull_top: FAILED **");
        $finish;
    end

    initial begin
        vis_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            vis_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && vis_if.valid === 1'b1 && vis_if.ready === 1'b1) begin
            cull_board.check_vis(vis_if.visibility);
        end
    end

    function automatic logic [PLANE_W-1:0] mk_plane(int nx, int ny, int nz, int off);
        t_plane p;
        p.nx = nx[NORM_W-1:0];
        p.ny = ny[NORM_W-1:0];
        p.nz = nz[NORM_W-1:0];
        p.offset = off[OFF_W-1:0];
        return p;
    endfunction

    function automatic t_box mk_box(int cx, int cy, int cz, int hx, int hy, int hz);
        t_box b;
        b.cx = cx[COORD_BITS-1:0];
        b.cy = cy[COORD_BITS-1:0];
        b.cz = cz[COORD_BITS-1:0];
        b.hx = hx[COORD_BITS-2:0];
        b.hy = hy[COORD_BITS-2:0];
        b.hz = hz[COORD_BITS-2:0];
        return b;
    endfunction

    function automatic void fill_axis(int w);
        plane_set[0] = mk_plane(UNIT_NORM, 0, 0, w);
        plane_set[1] = mk_plane(-UNIT_NORM, 0, 0, w);
        plane_set[2] = mk_plane(0, UNIT_NORM, 0, w);
        plane_set[3] = mk_plane(0, -UNIT_NORM, 0, w);
        plane_set[4] = mk_plane(0, 0, UNIT_NORM, w);
        plane_set[5] = mk_plane(0, 0, -UNIT_NORM, w);
    endfunction

    function automatic int scene_coord();
        return int'($urandom_range(3 * world_w)) - (3 * world_w) / 2;
    endfunction

    function automatic int scene_half();
        if ($urandom_range(3) == 0) begin
            return $urandom_range(16);
        end
        return $urandom_range(world_w / 2);
    endfunction

    function automatic t_box rand_box();
        t_box b;
        int   r, e;
        r = $urandom_range(99);
        if (r < 15) begin
            b.cx = COORD_BITS'($urandom);
            b.cy = COORD_BITS'($urandom);
            b.cz = COORD_BITS'($urandom);
            b.hx = (COORD_BITS-1)'($urandom);
            b.hy = (COORD_BITS-1)'($urandom);
            b.hz = (COORD_BITS-1)'($urandom);
        end else if (r < 35) begin
            // hug one face of the frustum within a few lsb
            b = mk_box(scene_coord() / 3, scene_coord() / 3, scene_coord() / 3,
                       $urandom_range(16), $urandom_range(16), $urandom_range(16));
            e = world_w + int'($urandom_range(20)) - 10;
            if ($urandom_range(1) == 1) e = -e;
            case ($urandom_range(2))
                0: b.cx = e[COORD_BITS-1:0];
                1: b.cy = e[COORD_BITS-1:0];
                default: b.cz = e[COORD_BITS-1:0];
            endcase
        end else begin
            b = mk_box(scene_coord(), scene_coord(), scene_coord(),
                       scene_half(), scene_half(), scene_half());
        end
        return b;
    endfunction

    task automatic send_box(input t_box b);
        while ($urandom_range(99) < gap_pct) begin
            box_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        box_if.valid    <= 1'b1;
        box_if.center_x <= b.cx;
        box_if.center_y <= b.cy;
        box_if.center_z <= b.cz;
        box_if.half_x   <= b.hx;
        box_if.half_y   <= b.hy;
        box_if.half_z   <= b.hz;
        do @(posedge i_clk); while (box_if.ready !== 1'b1);
        cull_board.note_box(b);
        @(negedge i_clk);
    endtask

    task automatic pause_until_drained();
        box_if.valid <= 1'b0;
        while (cull_board.pending_vis.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // leaves the write enable high so back-to-back writes need no toggle
    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [PLANE_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        cull_board.write_reg(idx, data);
        @(negedge i_clk);
    endtask

    task automatic write_one(input logic [CFG_IDX_W-1:0] idx, input logic [PLANE_W-1:0] data);
        write_cfg(idx, data);
        i_cfg_we <= 1'b0;
    endtask

    task automatic apply_planes(input logic [PLANE_W-1:0] eps_word);
        for (int i = 0; i < NUM_PLANES; i++) begin
            write_cfg(CFG_IDX_W'(i), plane_set[i]);
        end
        write_cfg(IDX_EPSILON, eps_word);
        i_cfg_we <= 1'b0;
        n_sets++;
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = '0;
        i_cfg_wdata     = '0;
        box_if.valid    = 1'b0;
        box_if.center_x = '0;
        box_if.center_y = '0;
        box_if.center_z = '0;
        box_if.half_x   = '0;
        box_if.half_y   = '0;
        box_if.half_z   = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset planes: zero normals, offset zero
        send_box(mk_box(0, 0, 0, 0, 0, 0));
        send_box(mk_box(MAX_C, MAX_C, MAX_C, MAX_H, MAX_H, MAX_H));
        send_box(mk_box(MIN_C, MIN_C, MIN_C, 0, 0, 0));
        send_box(mk_box(-1, -1, -1, 1, 1, 1));

        pause_until_drained();
        world_w = FRUSTUM_W;
        fill_axis(FRUSTUM_W);
        apply_planes(64'(EPS_RESET));
        send_box(mk_box(0, 0, 0, 256, 256, 256));
        send_box(mk_box(0, 0, 0, 2 * FRUSTUM_W, 2 * FRUSTUM_W, 2 * FRUSTUM_W));
        // exactly epsilon behind a face, then one lsb further
        send_box(mk_box(-FRUSTUM_W - 5, 0, 0, 0, 0, 0));
        send_box(mk_box(-FRUSTUM_W - 6, 0, 0, 0, 0, 0));
        send_box(mk_box(FRUSTUM_W + 5, 0, 0, 0, 0, 0));
        send_box(mk_box(0, 0, FRUSTUM_W + 6, 0, 0, 0));
        send_box(mk_box(-FRUSTUM_W + 10, 0, 0, 15, 0, 0));
        send_box(mk_box(-FRUSTUM_W + 10, 0, 0, 16, 0, 0));
        // partial on the x planes, then rejected by a y plane
        send_box(mk_box(0, -FRUSTUM_W - 100, 0, 2 * FRUSTUM_W, 50, 0));
        send_box(mk_box(MAX_C, 0, 0, MAX_H, 0, 0));
        send_box(mk_box(MIN_C, MIN_C, MIN_C, MAX_H, MAX_H, MAX_H));

        // zero normal: culls only on offset below minus epsilon
        pause_until_drained();
        write_one(IDX_LAST_PLANE, mk_plane(0, 0, 0, -6));
        send_box(mk_box(0, 0, 0, 0, 0, 0));
        pause_until_drained();
        write_one(IDX_LAST_PLANE, mk_plane(0, 0, 0, -5));
        send_box(mk_box(0, 0, 0, 0, 0, 0));

        for (int ph = 0; ph < 4; ph++) begin
            pause_until_drained();
            case (ph)
                0: begin
                    world_w = FRUSTUM_W;
                    fill_axis(FRUSTUM_W);
                    apply_planes(64'(EPS_RESET));
                    gap_pct = 0;
                    stall_pct = 0;
                end
                1: begin
                    world_w = FRUSTUM_W;
                    plane_set[0] = mk_plane(DIAG_NORM, 0, DIAG_NORM, FRUSTUM_W);
                    plane_set[1] = mk_plane(-DIAG_NORM, 0, DIAG_NORM, FRUSTUM_W);
                    plane_set[2] = mk_plane(0, MAX_NORM, 0, 2 * FRUSTUM_W);
                    plane_set[3] = mk_plane(0, MIN_NORM, 0, 2 * FRUSTUM_W);
                    plane_set[4] = mk_plane(1000, -1000, 4000, FRUSTUM_W);
                    plane_set[5] = mk_plane(0, 0, MIN_NORM, MAX_OFF);
                    apply_planes('0);
                    gap_pct = 58;
                    stall_pct = 0;
                end
                2: begin
                    world_w = FRUSTUM_W;
                    for (int i = 0; i < NUM_PLANES; i++) begin
                        if (i < 2) begin
                            plane_set[i] = {$urandom, $urandom};
                        end else begin
                            plane_set[i] = mk_plane($urandom, $urandom, $urandom,
                                int'($urandom_range(3 * FRUSTUM_W)) - FRUSTUM_W);
                        end
                    end
                    apply_planes({$urandom, $urandom} | 64'hFFFF);
                    gap_pct = 0;
                    stall_pct = 58;
                end
                default: begin
                    world_w = MAX_OFF;
                    fill_axis(MAX_OFF);
                    plane_set[5] = mk_plane(MAX_NORM, MAX_NORM, MAX_NORM, MIN_OFF);
                    apply_planes({$urandom, $urandom});
                    write_one(IDX_UNUSED, {$urandom, $urandom});
                    gap_pct = 20;
                    stall_pct = 20;
                end
            endcase
            for (int i = 0; i < ITEMS_PHASE; i++) begin
                if (i == ITEMS_PHASE / 2) pause_until_drained();
                send_box(rand_box());
            end
        end

        pause_until_drained();
        $display("%0d boxes checked across %0d plane settings and idle mixes",
                 cull_board.boxes, n_sets);
        $display("outcomes: %0d outside, %0d inside, %0d partial",
                 cull_board.seen[VIS_OUTSIDE], cull_board.seen[VIS_INSIDE],
                 cull_board.seen[VIS_PARTIAL]);
        if (cull_board.errors == 0 && cull_board.pending_vis.size() == 0) begin
            $display("** box_frustum_cull_top: PASSED **");
        end else begin
            $display("** box_frustum_cull_top: FAILED **");
        end
        $finish;
    end

endmodule
